@@ hdl/mtp3d_pkg.sv @@
// Package for the SS7 adaptation-layer deframer (M2UA / M2PA to MTP3).
// Holds the parser phase, result kind and status codes, protocol constants
// and the result record. No dependencies.
package mtp3d_pkg;

  // Capture protocol codes and common header values.
  localparam logic [7:0]  PROTO_M2UA = 8'h08;
  localparam logic [7:0]  PROTO_M2PA = 8'h0d;
  localparam logic [7:0]  CLASS_M2UA = 8'd6;
  localparam logic [7:0]  CLASS_M2PA = 8'd11;
  localparam logic [7:0]  VERSION_1  = 8'h01;
  localparam logic [7:0]  MSG_DATA   = 8'h01;
  localparam logic [15:0] TAG_DATA   = 16'h0300;

  // Parser phase.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR,
    PH_ELEM,
    PH_SKIP,
    PH_SEQ,
    PH_LABEL,
    PH_PAYLOAD,
    PH_TAIL
  } phase_e;

  // Result kind.
  typedef enum logic [1:0] {
    KIND_LABEL   = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  // Result status.
  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_SHORT    = 4'd1,
    ST_VERSION  = 4'd2,
    ST_RESERVED = 4'd3,
    ST_CLASS    = 4'd4,
    ST_TYPE     = 4'd5,
    ST_OVERRUN  = 4'd6,
    ST_ELEMENT  = 4'd7,
    ST_PADDING  = 4'd8,
    ST_NODATA   = 4'd9,
    ST_SEQSPACE = 4'd10,
    ST_EMPTY    = 4'd11,
    ST_PROTOCOL = 4'd12
  } status_e;

  // One result item as it travels from the parser to the output stage.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [13:0] origin_point;
    logic [13:0] dest_point;
    logic [3:0]  service_ind;
    logic [1:0]  network_ind;
    logic [3:0]  link_selection;
    logic [3:0]  status;
    logic        end_of_frame;
  } result_t;

endpackage

@@ hdl/mtp3d_if.sv @@
// Channel interfaces of the deframer: message bytes in, results out.
// Depends on mtp3d_pkg.
interface mtp3d_in_if import mtp3d_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;
  logic [7:0] protocol;

  modport source (output valid, data_byte, first_byte, last_byte, protocol, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, protocol, output ready);
endinterface

interface mtp3d_out_if import mtp3d_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [13:0] origin_point;
  logic [13:0] dest_point;
  logic [3:0]  service_ind;
  logic [1:0]  network_ind;
  logic [3:0]  link_selection;
  logic [3:0]  status;
  logic        end_of_frame;

  modport source (output valid, kind, payload_byte, origin_point, dest_point, service_ind,
                  network_ind, link_selection, status, end_of_frame, input ready);
  modport sink   (input valid, kind, payload_byte, origin_point, dest_point, service_ind,
                  network_ind, link_selection, status, end_of_frame, output ready);
endinterface

@@ hdl/mtp3d_parser.sv @@
// Per-byte parser of the deframer: header checks, element walk, M2PA skip,
// label split and payload pass-through. Depends on mtp3d_pkg.
module mtp3d_parser import mtp3d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       first_byte_i,
  input  logic       last_byte_i,
  input  logic [7:0] protocol_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  bif_q, bif_d;
  logic [31:0] decl_len_q, decl_len_d;
  logic [31:0] walk_q, walk_d;
  logic [15:0] tag_q, tag_d;
  logic [15:0] elem_len_q, elem_len_d;
  logic [1:0]  pad_q, pad_d;
  logic [31:0] pay_left_q, pay_left_d;
  logic [31:0] label_q, label_d;
  logic        m2pa_q, m2pa_d;

  // Next state and result for the byte on the inputs.
  always_comb begin
    logic        skip;
    logic        err;
    status_e     err_code;
    logic        hit;
    result_t     res;
    logic [2:0]  hi;
    logic [1:0]  ei;
    logic [15:0] len;
    logic [32:0] start;
    logic [32:0] room;
    logic [1:0]  pad;
    logic [31:0] rem;
    logic [31:0] word;
    logic [7:0]  b0;
    logic [2:0]  li;

    phase_d    = phase_q;
    bif_d      = bif_q;
    decl_len_d = decl_len_q;
    walk_d     = walk_q;
    tag_d      = tag_q;
    elem_len_d = elem_len_q;
    pad_d      = pad_q;
    pay_left_d = pay_left_q;
    label_d    = label_q;
    m2pa_d     = m2pa_q;
    skip       = 1'b0;
    err        = 1'b0;
    err_code   = ST_OK;
    hit        = 1'b0;
    res        = '0;
    hi         = bif_q[2:0];
    ei         = bif_q[1:0];
    len        = {elem_len_q[15:8], data_byte_i};
    start      = {1'b0, walk_q} + 33'd4;
    room       = '0;
    pad        = '0;
    rem        = '0;
    word       = '0;
    b0         = '0;
    li         = '0;

    // A first byte restarts the parser and picks the protocol.
    if (first_byte_i) begin
      bif_d      = '0;
      decl_len_d = '0;
      walk_d     = '0;
      tag_d      = '0;
      elem_len_d = '0;
      pad_d      = '0;
      pay_left_d = '0;
      label_d    = '0;
      if (protocol_i != PROTO_M2UA && protocol_i != PROTO_M2PA) begin
        m2pa_d   = 1'b0;
        err      = 1'b1;
        err_code = ST_PROTOCOL;
        skip     = 1'b1;
      end else begin
        m2pa_d  = (protocol_i == PROTO_M2PA);
        phase_d = PH_HDR;
      end
    end

    if (!skip && phase_d != PH_IDLE) begin
      if (phase_d == PH_HDR) begin
        // Common header: version, reserved, class, type, declared length.
        hi    = bif_d[2:0];
        bif_d = {1'b0, hi} + 4'd1;
        if (last_byte_i && (hi != 3'd7 || !m2pa_d)) begin
          err = 1'b1; err_code = ST_SHORT;
        end else if (hi == 3'd0 && data_byte_i != VERSION_1) begin
          err = 1'b1; err_code = ST_VERSION;
        end else if (hi == 3'd1 && data_byte_i != 8'd0) begin
          err = 1'b1; err_code = ST_RESERVED;
        end else if (hi == 3'd2 &&
                     data_byte_i != (m2pa_d ? CLASS_M2PA : CLASS_M2UA)) begin
          err = 1'b1; err_code = ST_CLASS;
        end else if (hi == 3'd3 && data_byte_i != MSG_DATA) begin
          err = 1'b1; err_code = ST_TYPE;
        end else if (hi[2]) begin
          decl_len_d = {decl_len_d[23:0], data_byte_i};
          if (hi == 3'd7) begin
            rem = decl_len_d - 32'd8;
            if (m2pa_d && last_byte_i && decl_len_d > 32'd8) begin
              err = 1'b1; err_code = ST_OVERRUN;
            end else if (decl_len_d < 32'd8) begin
              err = 1'b1; err_code = ST_SHORT;
            end else begin
              walk_d = rem;
              if (!m2pa_d) begin
                if (rem > 32'd4) begin
                  phase_d = PH_ELEM;
                  bif_d   = '0;
                end else begin
                  err = 1'b1; err_code = ST_NODATA;
                end
              end else if (rem < 32'd8) begin
                err = 1'b1; err_code = ST_SEQSPACE;
              end else if (rem == 32'd8) begin
                err = 1'b1; err_code = ST_EMPTY;
              end else if (rem < 32'd14) begin
                err = 1'b1; err_code = ST_SHORT;
              end else begin
                pay_left_d = rem - 32'd14;
                phase_d    = PH_SEQ;
                bif_d      = '0;
              end
            end
          end
        end
      end else begin
        // Body: every byte counts against the declared length.
        if (walk_d != 32'd0) begin
          walk_d = walk_d - 32'd1;
        end
        start = {1'b0, walk_d} + 33'd4;
        unique case (phase_d)
          PH_ELEM: begin
            // Tag and length of one M2UA element.
            ei    = bif_d[1:0];
            bif_d = {2'b00, ei} + 4'd1;
            unique case (ei)
              2'd0: tag_d      = {data_byte_i, 8'd0};
              2'd1: tag_d      = {tag_d[15:8], data_byte_i};
              2'd2: elem_len_d = {data_byte_i, 8'd0};
              default: begin
                len        = {elem_len_d[15:8], data_byte_i};
                elem_len_d = len;
                room       = start - {17'd0, len};
                pad        = 2'd0 - len[1:0];
                if (len < 16'd4 || {17'd0, len} > start) begin
                  err = 1'b1; err_code = ST_ELEMENT;
                end else if (tag_d == TAG_DATA) begin
                  if (len < 16'd9) begin
                    err = 1'b1; err_code = ST_SHORT;
                  end else begin
                    pay_left_d = {16'd0, len - 16'd9};
                    label_d    = '0;
                    bif_d      = '0;
                    phase_d    = PH_LABEL;
                  end
                end else if (room < {31'd0, pad}) begin
                  err = 1'b1; err_code = ST_PADDING;
                end else begin
                  elem_len_d = len - 16'd4;
                  pad_d      = pad;
                  if (elem_len_d == 16'd0 && pad == 2'd0) begin
                    if (walk_d > 32'd4) begin
                      phase_d = PH_ELEM;
                      bif_d   = '0;
                    end else begin
                      err = 1'b1; err_code = ST_NODATA;
                    end
                  end else begin
                    phase_d = PH_SKIP;
                  end
                end
              end
            endcase
          end
          PH_SKIP: begin
            // Element body first, then its padding.
            if (elem_len_d != 16'd0) begin
              elem_len_d = elem_len_d - 16'd1;
            end else if (pad_d != 2'd0) begin
              pad_d = pad_d - 2'd1;
            end
            if (elem_len_d == 16'd0 && pad_d == 2'd0) begin
              if (walk_d > 32'd4) begin
                phase_d = PH_ELEM;
                bif_d   = '0;
              end else begin
                err = 1'b1; err_code = ST_NODATA;
              end
            end
          end
          PH_SEQ: begin
            // Sequence numbers and the priority byte of M2PA.
            bif_d = bif_d + 4'd1;
            if (bif_d >= 4'd9) begin
              bif_d   = '0;
              label_d = '0;
              phase_d = PH_LABEL;
            end
          end
          PH_LABEL: begin
            // Collect label bytes; the fifth one completes the label.
            li    = (bif_d > 4'd4) ? 3'd4 : bif_d[2:0];
            bif_d = {1'b0, li} + 4'd1;
            if (li == 3'd4) begin
              b0   = label_d[7:0];
              word = {data_byte_i, label_d[31:8]};
              hit  = 1'b1;
              res.kind           = KIND_LABEL;
              res.origin_point   = word[27:14];
              res.dest_point     = word[13:0];
              res.service_ind    = b0[3:0];
              res.network_ind    = b0[7:6];
              res.link_selection = word[31:28];
              if (pay_left_d == 32'd0) begin
                res.end_of_frame = 1'b1;
                phase_d          = PH_TAIL;
              end else begin
                phase_d = PH_PAYLOAD;
              end
            end else begin
              label_d[li[1:0]*8 +: 8] = data_byte_i;
            end
          end
          PH_PAYLOAD: begin
            hit              = 1'b1;
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = data_byte_i;
            if (pay_left_d != 32'd0) begin
              pay_left_d = pay_left_d - 32'd1;
            end
            if (pay_left_d == 32'd0) begin
              res.end_of_frame = 1'b1;
              phase_d          = PH_TAIL;
            end
          end
          default: begin
          end
        endcase
        // Message ends while declared bytes are still missing.
        if (last_byte_i && walk_d != 32'd0) begin
          err = 1'b1; err_code = ST_OVERRUN;
        end
      end
      if (last_byte_i) begin
        phase_d = PH_IDLE;
      end
    end

    // An error replaces any other result and parks the parser.
    if (err) begin
      res              = '0;
      res.kind         = KIND_ERROR;
      res.status       = err_code;
      res.end_of_frame = 1'b1;
      hit              = 1'b1;
      phase_d          = PH_IDLE;
    end

    res_valid_o = accept_i && hit;
    res_o       = res;
  end

  // Parser state registers, updated on each accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      bif_q      <= '0;
      decl_len_q <= '0;
      walk_q     <= '0;
      tag_q      <= '0;
      elem_len_q <= '0;
      pad_q      <= '0;
      pay_left_q <= '0;
      label_q    <= '0;
      m2pa_q     <= 1'b0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      bif_q      <= bif_d;
      decl_len_q <= decl_len_d;
      walk_q     <= walk_d;
      tag_q      <= tag_d;
      elem_len_q <= elem_len_d;
      pad_q      <= pad_d;
      pay_left_q <= pay_left_d;
      label_q    <= label_d;
      m2pa_q     <= m2pa_d;
    end
  end

endmodule

@@ hdl/mtp3d_skid.sv @@
// Result register with a skid stage, so the input side keeps flowing while
// a result waits on the output. Depends on mtp3d_pkg.
module mtp3d_skid import mtp3d_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;

  // Upstream may push whenever the skid stage is free.
  assign ready_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Control: the output register refills from the skid stage first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      out_q <= skid_valid_q ? skid_q : push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

endmodule

@@ hdl/ss7_adaptation_mtp3_deframer.sv @@
// Top level of the SS7 adaptation-layer deframer (M2UA / M2PA to MTP3 label
// and payload). Depends on mtp3d_pkg, mtp3d_if, mtp3d_parser, mtp3d_skid.
//
//   channel  direction  carries
//   in_i     sink       data_byte, first_byte, last_byte, protocol
//   out_o    source     kind, payload_byte, label fields, status, end_of_frame
//
// One byte is taken per cycle while in_i.ready is high; each byte gives at
// most one result, registered for out_o, via the skid stage if out_o stalls.
// The per-byte parser state updates in the same cycle the byte is accepted.
// A two-entry result stage (output register plus skid) lets input continue
// while out_o is stalled; in_i.ready falls only when both entries are full.
// The asynchronous reset returns the parser to idle and empties the results.
module ss7_adaptation_mtp3_deframer import mtp3d_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  mtp3d_in_if.sink    in_i,
  mtp3d_out_if.source out_o
);

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_data;
  logic    skid_ready;

  assign in_i.ready = skid_ready;
  assign accept     = in_i.valid && skid_ready;

  // Per-byte parser.
  mtp3d_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (in_i.data_byte),
    .first_byte_i (in_i.first_byte),
    .last_byte_i  (in_i.last_byte),
    .protocol_i   (in_i.protocol),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Result register and skid stage.
  mtp3d_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .ready_o     (skid_ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

  // Result fields onto the output channel.
  assign out_o.kind           = out_data.kind;
  assign out_o.payload_byte   = out_data.payload_byte;
  assign out_o.origin_point   = out_data.origin_point;
  assign out_o.dest_point     = out_data.dest_point;
  assign out_o.service_ind    = out_data.service_ind;
  assign out_o.network_ind    = out_data.network_ind;
  assign out_o.link_selection = out_data.link_selection;
  assign out_o.status         = out_data.status;
  assign out_o.end_of_frame   = out_data.end_of_frame;

endmodule

@@ hdl/mtp3d_checker.sv @@
// Port-level checks of the deframer's result channel, and the bind that
// attaches them to the top level. Depends on mtp3d_pkg.
module mtp3d_checker import mtp3d_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  kind_i,
  input logic [13:0] origin_point_i,
  input logic [13:0] dest_point_i,
  input logic [3:0]  status_i,
  input logic        end_of_frame_i
);

  // A result that is not taken stays offered.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // Every error closes the message and carries a nonzero status.
  a_err_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == KIND_ERROR |-> end_of_frame_i && status_i != ST_OK)
    else $error("error result without end_of_frame or status");

  // Label and payload results report status ok.
  a_ok_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != KIND_ERROR |-> status_i == ST_OK)
    else $error("non-error result with nonzero status");

  // Payload results carry no point codes.
  a_pay_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == KIND_PAYLOAD |-> origin_point_i == 14'd0 && dest_point_i == 14'd0)
    else $error("payload result with point codes");

  // Only the three defined kinds appear.
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> kind_i == KIND_LABEL || kind_i == KIND_PAYLOAD || kind_i == KIND_ERROR)
    else $error("undefined result kind");

endmodule

bind ss7_adaptation_mtp3_deframer mtp3d_checker u_mtp3d_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .kind_i         (out_o.kind),
  .origin_point_i (out_o.origin_point),
  .dest_point_i   (out_o.dest_point),
  .status_i       (out_o.status),
  .end_of_frame_i (out_o.end_of_frame)
);

@@ verif/ss7_adaptation_mtp3_deframer_tb.sv @@
// Self-checking testbench for the SS7 adaptation-layer deframer (M2UA / M2PA to MTP3).
// It sends framed message bytes, predicts labels, payload bytes and errors, and checks
// every result transaction. Depends on mtp3d_pkg, mtp3d_if and the deframer top level.
module ss7_adaptation_mtp3_deframer_tb;
  import mtp3d_pkg::*;

  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned RandomBytes = 650;
  localparam int unsigned MaxReports  = 10;

  logic clk_i;
  logic rst_ni;

  mtp3d_in_if  in_if ();
  mtp3d_out_if out_if ();

  ss7_adaptation_mtp3_deframer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Idle limits of the two sides, changed from test to test.
  int unsigned src_gap_max = 0;
  int unsigned snk_gap_max = 0;

  // Results predicted for accepted bytes and not yet seen on the output.
  result_t     pending_results[$];
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;

  // Message under construction, one byte per entry.
  logic [7:0] frame_q[$];

  // Parser state as the predictor tracks it.
  phase_e      st_phase     = PH_IDLE;
  int unsigned st_count     = 0;
  logic [31:0] st_decl      = '0;
  logic [31:0] st_body_left = '0;
  logic [15:0] st_tag       = '0;
  logic [15:0] st_elem      = '0;
  logic [1:0]  st_pad       = '0;
  logic [31:0] st_user_left = '0;
  logic [39:0] st_label     = '0;
  logic        st_m2pa      = 1'b0;

  // Outcome of the most recent predicted byte.
  result_t next_res;
  bit      next_has;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void flag_error(input status_e code);
    next_res              = '0;
    next_res.kind         = KIND_ERROR;
    next_res.status       = code;
    next_res.end_of_frame = 1'b1;
    next_has              = 1'b1;
    st_phase              = PH_IDLE;
  endfunction

  // Another element must fit in what is left of the declared length.
  function automatic void next_element();
    if (st_body_left > 4) begin
      st_phase = PH_ELEM;
      st_count = 0;
    end else begin
      flag_error(ST_NODATA);
    end
  endfunction

  // Advances the parser by one accepted byte and sets next_res / next_has.
  function automatic void deframe_byte(input logic [7:0] b, input logic first,
                                       input logic last, input logic [7:0] proto);
    int unsigned idx;
    logic [32:0] room;
    logic [15:0] len;
    logic [1:0]  pad;
    logic [31:0] word;
    next_res = '0;
    next_has = 1'b0;

    // A first byte restarts everything and selects the protocol.
    if (first) begin
      st_count     = 0;
      st_decl      = '0;
      st_body_left = '0;
      st_tag       = '0;
      st_elem      = '0;
      st_pad       = '0;
      st_user_left = '0;
      st_label     = '0;
      if (proto != PROTO_M2UA && proto != PROTO_M2PA) begin
        st_m2pa = 1'b0;
        flag_error(ST_PROTOCOL);
        return;
      end
      st_m2pa  = (proto == PROTO_M2PA);
      st_phase = PH_HDR;
    end
    if (st_phase == PH_IDLE) return;

    if (st_phase == PH_HDR) begin
      // Common header: version, reserved, class, type, then the length.
      idx      = st_count & 7;
      st_count = idx + 1;
      if (last && (idx < 7 || !st_m2pa)) begin
        flag_error(ST_SHORT);
      end else if (idx == 0 && b != VERSION_1) begin
        flag_error(ST_VERSION);
      end else if (idx == 1 && b != 8'h00) begin
        flag_error(ST_RESERVED);
      end else if (idx == 2 && b != (st_m2pa ? CLASS_M2PA : CLASS_M2UA)) begin
        flag_error(ST_CLASS);
      end else if (idx == 3 && b != MSG_DATA) begin
        flag_error(ST_TYPE);
      end else if (idx >= 4) begin
        st_decl = {st_decl[23:0], b};
        if (idx == 7) begin
          if (st_m2pa && last && st_decl > 8) begin
            flag_error(ST_OVERRUN);
          end else if (st_decl < 8) begin
            flag_error(ST_SHORT);
          end else begin
            st_body_left = st_decl - 8;
            if (!st_m2pa) begin
              next_element();
            end else if (st_body_left < 8) begin
              flag_error(ST_SEQSPACE);
            end else if (st_body_left == 8) begin
              flag_error(ST_EMPTY);
            end else if (st_body_left < 14) begin
              flag_error(ST_SHORT);
            end else begin
              st_user_left = st_body_left - 14;
              st_phase     = PH_SEQ;
              st_count     = 0;
            end
          end
        end
      end
    end else begin
      if (st_body_left > 0) st_body_left--;
      case (st_phase)
        // Element header: tag and length, both big-endian.
        PH_ELEM: begin
          idx      = st_count & 3;
          st_count = idx + 1;
          case (idx)
            0: st_tag = {b, 8'h00};
            1: st_tag[7:0] = b;
            2: st_elem = {b, 8'h00};
            default: begin
              len  = st_elem | {8'h00, b};
              room = {1'b0, st_body_left} + 33'd4;
              if (len < 4 || len > room) begin
                flag_error(ST_ELEMENT);
              end else if (st_tag == TAG_DATA) begin
                if (len < 9) begin
                  flag_error(ST_SHORT);
                end else begin
                  st_user_left = {16'h0000, len} - 32'd9;
                  st_label     = '0;
                  st_count     = 0;
                  st_phase     = PH_LABEL;
                end
              end else begin
                pad = 2'd0 - len[1:0];
                if (room - len < pad) begin
                  flag_error(ST_PADDING);
                end else begin
                  st_elem = len - 16'd4;
                  st_pad  = pad;
                  if (st_elem == 0 && st_pad == 0) next_element();
                  else st_phase = PH_SKIP;
                end
              end
            end
          endcase
        end
        // Body of a skipped element, then its padding.
        PH_SKIP: begin
          if (st_elem > 0) st_elem--;
          else if (st_pad > 0) st_pad--;
          if (st_elem == 0 && st_pad == 0) next_element();
        end
        // Sequence numbers and priority byte of M2PA.
        PH_SEQ: begin
          st_count++;
          if (st_count >= 9) begin
            st_count = 0;
            st_label = '0;
            st_phase = PH_LABEL;
          end
        end
        // Routing label: one service byte and a little-endian word.
        PH_LABEL: begin
          idx      = (st_count > 4) ? 4 : st_count;
          st_label = st_label | (40'(b) << (8 * idx));
          st_count = idx + 1;
          if (st_count >= 5) begin
            word                    = st_label[39:8];
            next_res.kind           = KIND_LABEL;
            next_res.origin_point   = word[27:14];
            next_res.dest_point     = word[13:0];
            next_res.service_ind    = st_label[3:0];
            next_res.network_ind    = st_label[7:6];
            next_res.link_selection = word[31:28];
            next_has                = 1'b1;
            if (st_user_left == 0) begin
              next_res.end_of_frame = 1'b1;
              st_phase              = PH_TAIL;
            end else begin
              st_phase = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          next_res.kind         = KIND_PAYLOAD;
          next_res.payload_byte = b;
          next_has              = 1'b1;
          if (st_user_left > 0) st_user_left--;
          if (st_user_left == 0) begin
            next_res.end_of_frame = 1'b1;
            st_phase              = PH_TAIL;
          end
        end
        default: begin
        end
      endcase
      // Declared bytes still missing when the message ends.
      if (last && st_body_left > 0) flag_error(ST_OVERRUN);
    end
    if (last) st_phase = PH_IDLE;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void report_mismatch(input string what, input result_t want,
                                          input result_t got);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected kind=%0d byte=%h opc=%0d dpc=%0d si=%0d ni=%0d sls=%0d st=%0d eof=%b",
               want.kind, want.payload_byte, want.origin_point, want.dest_point,
               want.service_ind, want.network_ind, want.link_selection, want.status,
               want.end_of_frame);
      $display("  actual   kind=%0d byte=%h opc=%0d dpc=%0d si=%0d ni=%0d sls=%0d st=%0d eof=%b",
               got.kind, got.payload_byte, got.origin_point, got.dest_point,
               got.service_ind, got.network_ind, got.link_selection, got.status,
               got.end_of_frame);
    end
  endfunction

  // Predict on every input transaction, compare on every output transaction.
  always @(posedge clk_i) begin : scoreboard
    result_t want;
    result_t got;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        deframe_byte(in_if.data_byte, in_if.first_byte, in_if.last_byte, in_if.protocol);
        if (next_has) pending_results.push_back(next_res);
      end
      if (out_if.valid && out_if.ready) begin
        got.kind           = out_if.kind;
        got.payload_byte   = out_if.payload_byte;
        got.origin_point   = out_if.origin_point;
        got.dest_point     = out_if.dest_point;
        got.service_ind    = out_if.service_ind;
        got.network_ind    = out_if.network_ind;
        got.link_selection = out_if.link_selection;
        got.status         = out_if.status;
        got.end_of_frame   = out_if.end_of_frame;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing expected", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
              got.origin_point !== want.origin_point || got.dest_point !== want.dest_point ||
              got.service_ind !== want.service_ind || got.network_ind !== want.network_ind ||
              got.link_selection !== want.link_selection || got.status !== want.status ||
              got.end_of_frame !== want.end_of_frame) begin
            report_mismatch("result mismatch", want, got);
          end
        end
      end
    end
  end

  // Ends the run when neither side moves for too long.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Result side: after each transaction, hold ready low for a random stall.
  initial begin : result_sink
    int unsigned hold;
    bit took;
    out_if.ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      took = out_if.valid && out_if.ready;
      @(negedge clk_i);
      if (took) hold = $urandom_range(0, snk_gap_max);
      if (hold != 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Sends one byte transaction; called and returns at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic first, input logic last,
                           input logic [7:0] proto);
    int unsigned gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= b;
    in_if.first_byte <= first;
    in_if.last_byte  <= last;
    in_if.protocol   <= proto;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Sends frame_q; the protocol is only meaningful on the first byte.
  task automatic send_frame(input logic [7:0] proto, input bit close);
    int unsigned i;
    for (i = 0; i < frame_q.size(); i++) begin
      send_byte(frame_q[i], i == 0, close && (i == frame_q.size() - 1),
                (i == 0) ? proto : 8'($urandom_range(0, 255)));
    end
  endtask

  // Waits until every predicted result has arrived, then a short hold-off.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  function automatic int unsigned pick_gap();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 11;
      default: return $urandom_range(1, 11);
    endcase
  endfunction

  function automatic void open_frame(input bit m2pa);
    frame_q.delete();
    frame_q.push_back(VERSION_1);
    frame_q.push_back(8'h00);
    frame_q.push_back(m2pa ? CLASS_M2PA : CLASS_M2UA);
    frame_q.push_back(MSG_DATA);
    repeat (4) frame_q.push_back(8'h00);
  endfunction

  function automatic void set_length(input logic [31:0] n);
    frame_q[4] = n[31:24];
    frame_q[5] = n[23:16];
    frame_q[6] = n[15:8];
    frame_q[7] = n[7:0];
  endfunction

  function automatic void cut_frame(input int unsigned n);
    while (frame_q.size() > n) void'(frame_q.pop_back());
  endfunction

  // Tag/length element with random body, padded to a multiple of four bytes.
  function automatic void add_element(input logic [15:0] tag, input logic [15:0] len);
    int unsigned k;
    frame_q.push_back(tag[15:8]);
    frame_q.push_back(tag[7:0]);
    frame_q.push_back(len[15:8]);
    frame_q.push_back(len[7:0]);
    for (k = 4; k < len; k++) frame_q.push_back(8'($urandom_range(0, 255)));
    while (frame_q.size() % 4 != 0) frame_q.push_back(8'h00);
  endfunction

  // Well-formed message with random label and payload.
  function automatic void make_frame(input bit m2pa, input int unsigned n_other,
                                     input int unsigned n_pay);
    logic [15:0] tag;
    open_frame(m2pa);
    if (m2pa) begin
      repeat (14 + n_pay) frame_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat (n_other) begin
        tag = 16'($urandom_range(0, 16'hffff));
        if (tag == TAG_DATA) tag = 16'h0001;
        add_element(tag, 16'($urandom_range(4, 14)));
      end
      add_element(TAG_DATA, 16'(9 + n_pay));
    end
    set_length(frame_q.size());
  endfunction

  // One random defect in the current message.
  function automatic void damage_frame();
    case ($urandom_range(0, 5))
      0: frame_q[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
      1: set_length($urandom_range(0, 1) ? $urandom() :
                    32'(frame_q.size() + $urandom_range(0, 20) - 10));
      2: cut_frame($urandom_range(1, frame_q.size()));
      3: begin
        frame_q[10] = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255));
        frame_q[11] = 8'($urandom_range(0, 255));
      end
      4: frame_q[$urandom_range(8, frame_q.size() - 1)] = 8'($urandom_range(0, 255));
      default: frame_q[$urandom_range(8, 9)] = 8'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Clean messages: label extremes, empty and short payloads, skipped elements.
  task automatic test_clean_frames();
    int unsigned i;
    src_gap_max = 0;
    snk_gap_max = 0;
    make_frame(1'b0, 0, 3);
    for (i = 0; i < 5; i++) frame_q[12 + i] = 8'hff;
    send_frame(PROTO_M2UA, 1'b1);
    make_frame(1'b0, 0, 0);
    for (i = 0; i < 5; i++) frame_q[12 + i] = 8'h00;
    send_frame(PROTO_M2UA, 1'b1);
    src_gap_max = 11;
    snk_gap_max = 11;
    open_frame(1'b0);
    add_element(16'h0001, 16'd4);
    add_element(16'hffff, 16'd5);
    add_element(TAG_DATA, 16'd11);
    set_length(frame_q.size());
    send_frame(PROTO_M2UA, 1'b1);
    make_frame(1'b1, 0, 2);
    for (i = 0; i < 5; i++) frame_q[17 + i] = 8'hff;
    send_frame(PROTO_M2PA, 1'b1);
    make_frame(1'b1, 0, 0);
    send_frame(PROTO_M2PA, 1'b1);
    // Bytes beyond the declared length are ignored.
    make_frame(1'b0, 0, 1);
    repeat (3) frame_q.push_back(8'($urandom_range(0, 255)));
    send_frame(PROTO_M2UA, 1'b1);
    drain();
  endtask

  // Header field errors, unknown protocol and messages ending in the header.
  task automatic test_header_errors();
    src_gap_max = pick_gap();
    snk_gap_max = pick_gap();
    make_frame(1'b0, 0, 1);
    frame_q[0] = 8'h02;
    send_frame(PROTO_M2UA, 1'b1);
    make_frame(1'b0, 0, 1);
    frame_q[1] = 8'hff;
    send_frame(PROTO_M2UA, 1'b1);
    make_frame(1'b1, 0, 1);
    frame_q[2] = CLASS_M2UA;
    send_frame(PROTO_M2PA, 1'b1);
    make_frame(1'b0, 0, 1);
    frame_q[3] = 8'h00;
    send_frame(PROTO_M2UA, 1'b1);
    make_frame(1'b0, 0, 0);
    send_frame(8'hff, 1'b1);
    send_byte(8'h00, 1'b1, 1'b1, 8'h00);
    make_frame(1'b0, 0, 1);
    cut_frame(4);
    send_frame(PROTO_M2UA, 1'b1);
    make_frame(1'b0, 0, 1);
    cut_frame(8);
    send_frame(PROTO_M2UA, 1'b1);
    make_frame(1'b1, 0, 1);
    cut_frame(8);
    send_frame(PROTO_M2PA, 1'b1);
    make_frame(1'b0, 0, 1);
    set_length(32'd5);
    send_frame(PROTO_M2UA, 1'b1);
    drain();
  endtask

  // Element and sequence-space errors in the message body.
  task automatic test_body_errors();
    src_gap_max = pick_gap();
    snk_gap_max = pick_gap();
    open_frame(1'b0);
    add_element(16'h0001, 16'd2);
    repeat (12) frame_q.push_back(8'($urandom_range(0, 255)));
    set_length(frame_q.size());
    send_frame(PROTO_M2UA, 1'b1);
    open_frame(1'b0);
    add_element(16'h0001, 16'd8);
    set_length(frame_q.size());
    frame_q[10] = 8'h00;
    frame_q[11] = 8'd200;
    send_frame(PROTO_M2UA, 1'b1);
    // Element of five bytes with no room left for its padding.
    open_frame(1'b0);
    add_element(16'h0001, 16'd5);
    set_length(32'd13);
    send_frame(PROTO_M2UA, 1'b1);
    open_frame(1'b0);
    add_element(16'h0001, 16'd4);
    add_element(16'h0002, 16'd4);
    set_length(frame_q.size());
    send_frame(PROTO_M2UA, 1'b1);
    open_frame(1'b0);
    add_element(TAG_DATA, 16'd8);
    set_length(frame_q.size());
    send_frame(PROTO_M2UA, 1'b1);
    // M2PA with too little room for sequence numbers, no label, or a short label.
    open_frame(1'b1);
    repeat (4) frame_q.push_back(8'($urandom_range(0, 255)));
    set_length(frame_q.size());
    send_frame(PROTO_M2PA, 1'b1);
    open_frame(1'b1);
    repeat (8) frame_q.push_back(8'($urandom_range(0, 255)));
    set_length(frame_q.size());
    send_frame(PROTO_M2PA, 1'b1);
    open_frame(1'b1);
    repeat (11) frame_q.push_back(8'($urandom_range(0, 255)));
    set_length(frame_q.size());
    send_frame(PROTO_M2PA, 1'b1);
    drain();
  endtask

  // Overruns, messages cut by a new first byte, and bytes while idle.
  task automatic test_overrun_and_stray();
    src_gap_max = pick_gap();
    snk_gap_max = pick_gap();
    make_frame(1'b1, 0, 4);
    set_length(frame_q.size() + 10);
    send_frame(PROTO_M2PA, 1'b1);
    // Overrun after the last payload byte was already marked as frame end.
    make_frame(1'b0, 0, 2);
    set_length(frame_q.size() + 8);
    send_frame(PROTO_M2UA, 1'b1);
    make_frame(1'b0, 1, 6);
    cut_frame(frame_q.size() - 3);
    send_frame(PROTO_M2UA, 1'b0);
    make_frame(1'b1, 0, 1);
    send_frame(PROTO_M2PA, 1'b1);
    send_byte(8'h5a, 1'b0, 1'b0, 8'h08);
    send_byte(8'ha5, 1'b0, 1'b1, 8'h0d);
    drain();
  endtask

  // Mostly well-formed messages with random content, plus defects and noise.
  task automatic test_random_traffic();
    int unsigned counted;
    int unsigned pick;
    int unsigned n_pay;
    bit          m2pa;
    logic [7:0]  proto;
    counted = 0;
    while (counted < RandomBytes) begin
      src_gap_max = pick_gap();
      snk_gap_max = pick_gap();
      pick        = $urandom_range(0, 99);
      m2pa        = 1'($urandom_range(0, 1));
      proto       = m2pa ? PROTO_M2PA : PROTO_M2UA;
      n_pay = ($urandom_range(0, 24) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 12);
      make_frame(m2pa, $urandom_range(0, 3), n_pay);
      if (pick < 60) begin
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom_range(0, 255)));
        end
        send_frame(proto, 1'b1);
      end else if (pick < 85) begin
        damage_frame();
        send_frame(proto, 1'b1);
      end else if (pick < 92) begin
        cut_frame($urandom_range(1, frame_q.size()));
        send_frame(proto, 1'b0);
      end else if (pick < 96) begin
        send_frame(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        // Stray bytes; ignored unless a message is still open.
        repeat ($urandom_range(1, 4)) begin
          send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                    8'($urandom_range(0, 255)));
        end
        continue;
      end
      counted += frame_q.size();
      if ($urandom_range(0, 29) == 0) drain();
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.data_byte  = 8'h00;
    in_if.first_byte = 1'b0;
    in_if.last_byte  = 1'b0;
    in_if.protocol   = 8'h00;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_clean_frames();
    test_header_errors();
    test_body_errors();
    test_overrun_and_stray();
    test_random_traffic();

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
